// ----- rtl/core/ccc_pkg.sv -----
package ccc_pkg;

    localparam int YEAR_BITS = 16;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX     = {YEAR_BITS{1'b1}};
    localparam logic [YEAR_BITS-1:0] YEAR_DEFAULT = YEAR_BITS'(2000);

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;
    localparam logic [4:0] HOUR_NOON = 5'd12;

    localparam logic [4:0] LEN_31 = 5'd31;
    localparam logic [4:0] LEN_30 = 5'd30;
    localparam logic [4:0] LEN_29 = 5'd29;
    localparam logic [4:0] LEN_28 = 5'd28;

    // Inverse of an odd constant modulo 2^64 (Newton iteration, bits double each pass).
    function automatic logic [63:0] mod_inverse(input logic [63:0] d);
        logic [63:0] x;
        x = d;
        for (int i = 0; i < 6; i++)
        begin
            x = x * (64'd2 - d * x);
        end
        return x;
    endfunction

    // y % 25 == 0  <=>  (y * inv25 mod 2^n) <= (2^n - 1) / 25
    localparam logic [YEAR_BITS-1:0] INV25       = YEAR_BITS'(mod_inverse(64'd25));
    localparam logic [YEAR_BITS-1:0] DIV25_LIMIT =
        YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

    typedef struct packed {
        logic        func;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [15:0] set_year;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } req_t;

    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [15:0] cur_year;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [3:0]  hour_twelve;
        logic        is_pm;
    } rsp_t;

endpackage

// ----- rtl/core/calendar_clock_counter.sv -----
// Result: a result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle; the result register is the only buffer,
// so req_stall rises only while a held result is stalled by rsp_stall.
// Reset: time 00:00:00, date January 1, year 2000; no result pending.
// Month length (leap test via one modular multiply) sets the critical path.
module calendar_clock_counter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ccc_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ccc_pkg::rsp_t rsp_data
);
    import ccc_pkg::*;

    logic [5:0]           sec_reg,   sec_next;
    logic [5:0]           min_reg,   min_next;
    logic [4:0]           hour_reg,  hour_next;
    logic [4:0]           day_reg,   day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg,  year_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg,   rsp_next;

    logic                 accept;
    logic                 is_set;
    logic [YEAR_BITS-1:0] y_load, y_set;
    logic [3:0]           m_set;
    logic [4:0]           d_set;
    logic [YEAR_BITS-1:0] len_year;
    logic [3:0]           len_month;
    logic [4:0]           len;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign is_set    = (req_data.func == FUNC_SET);

    assign y_load = YEAR_BITS'(req_data.set_year);
    assign y_set  = (y_load == '0) ? YEAR_DEFAULT : y_load;
    assign m_set  = (req_data.set_month >= MON_JAN && req_data.set_month <= MON_DEC)
                    ? req_data.set_month : MON_JAN;

    // one length unit: a tick needs the current month, a set the loaded one
    assign len_year  = is_set ? y_set : year_reg;
    assign len_month = is_set ? m_set : month_reg;

    ccc_month_len u_month_len (
        .month (len_month),
        .year  (len_year),
        .len   (len)
    );

    assign d_set = (req_data.set_day != 5'd0 && req_data.set_day <= len)
                   ? req_data.set_day : 5'd1;

    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        if (is_set)
        begin
            year_next  = y_set;
            month_next = m_set;
            day_next   = d_set;
            hour_next  = (req_data.set_hour   <= HOUR_LAST) ? req_data.set_hour   : 5'd0;
            min_next   = (req_data.set_minute <= MIN_LAST)  ? req_data.set_minute : 6'd0;
            sec_next   = (req_data.set_second <= SEC_LAST)  ? req_data.set_second : 6'd0;
        end
        else if (sec_reg < SEC_LAST)
        begin
            sec_next = sec_reg + 6'd1;
        end
        else
        begin
            sec_next = 6'd0;
            if (min_reg < MIN_LAST)
            begin
                min_next = min_reg + 6'd1;
            end
            else
            begin
                min_next = 6'd0;
                if (hour_reg < HOUR_LAST)
                begin
                    hour_next = hour_reg + 5'd1;
                end
                else
                begin
                    hour_next = 5'd0;
                    if (day_reg < len)
                    begin
                        day_next = day_reg + 5'd1;
                    end
                    else
                    begin
                        day_next = 5'd1;
                        if (month_reg < MON_DEC)
                        begin
                            month_next = month_reg + 4'd1;
                        end
                        else
                        begin
                            month_next = MON_JAN;
                            if (year_reg != YEAR_MAX)
                            begin
                                year_next = year_reg + YEAR_BITS'(1);
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        rsp_next.cur_month  = month_next;
        rsp_next.cur_day    = day_next;
        rsp_next.cur_year   = 16'(year_next);
        rsp_next.cur_hour   = hour_next;
        rsp_next.cur_minute = min_next;
        rsp_next.cur_second = sec_next;
        rsp_next.is_pm      = (hour_next >= HOUR_NOON);
        if (hour_next == 5'd0)
            rsp_next.hour_twelve = 4'd12;
        else if (hour_next > HOUR_NOON)
            rsp_next.hour_twelve = 4'(hour_next - HOUR_NOON);
        else
            rsp_next.hour_twelve = 4'(hour_next);
    end

    always_comb
    begin
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            day_reg       <= 5'd1;
            month_reg     <= MON_JAN;
            year_reg      <= YEAR_DEFAULT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                sec_reg   <= sec_next;
                min_reg   <= min_next;
                hour_reg  <= hour_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        month_reg >= MON_JAN && month_reg <= MON_DEC && day_reg != 5'd0
        && hour_reg <= HOUR_LAST && min_reg <= MIN_LAST && sec_reg <= SEC_LAST)
        else $error("calendar state out of range");

    a_plain_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_data.func == FUNC_TICK && sec_reg < SEC_LAST
        |=> sec_reg == $past(sec_reg) + 6'd1 && min_reg == $past(min_reg)
            && day_reg == $past(day_reg))
        else $error("tick without carry disturbed upper counters");

    a_rsp_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.cur_second == sec_reg && rsp_reg.cur_minute == min_reg
            && rsp_reg.cur_hour == hour_reg && rsp_reg.cur_day == day_reg)
        else $error("result beat does not match counters");

    a_pm_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.is_pm == (rsp_reg.cur_hour >= HOUR_NOON)
            && rsp_reg.hour_twelve != 4'd0)
        else $error("12-hour display inconsistent");

endmodule

// ----- rtl/core/ccc_month_len.sv -----
module ccc_month_len (
    input  logic [3:0]                    month,
    input  logic [ccc_pkg::YEAR_BITS-1:0] year,
    output logic [4:0]                    len
);
    import ccc_pkg::*;

    logic [YEAR_BITS-1:0] prod;
    logic                 div25;
    logic                 leap;

    assign prod  = year * INV25;
    assign div25 = (prod <= DIV25_LIMIT);
    // div by 100 = div by 4 and 25; div by 400 = div by 16 and 25
    assign leap  = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

    always_comb
    begin
        unique case (month) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
            MON_FEB:                            len = leap ? LEN_29 : LEN_28;
            default:                            len = LEN_31;
        endcase
    end

endmodule
